FILE: src/utrb_pkg.sv
// Shared types and constants for the UART transmit and receive ring buffers.
package utrb_pkg;

	localparam int QUEUE_DEPTH = 512;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LEVEL_W = 10;
	localparam int DATA_W = 8;

	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(QUEUE_DEPTH);
	localparam logic [FILL_W-1:0] FILL_ALMOST_FULL = FILL_W'(QUEUE_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	typedef enum logic [1:0] {
		CMD_PUT = 2'd0,
		CMD_GET = 2'd1,
		CMD_TXRDY = 2'd2,
		CMD_RXBYTE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
		return n;
	endfunction

endpackage

FILE: src/utrb_ctrl.sv
// Controller state machine that sequences capture, execution and result strobe.
module utrb_ctrl
	import utrb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output ctrl_cmd_t ctrl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DONE
	} state_t;

	state_t state_q;
	logic busy_q;
	logic done_q;
	logic accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q <= 1'b1;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				S_DONE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q <= 1'b0;
					done_q <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign ctrl.load = accept;
	assign ctrl.exec = (state_q == S_EXEC);

endmodule

FILE: src/utrb_dp.sv
// Datapath with the two byte queues, their pointers, fill counts and interrupt enables.
module utrb_dp
	import utrb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         ctrl,
	input  logic [1:0]        cmd,
	input  logic [DATA_W-1:0] data_in,
	output logic              status,
	output logic [DATA_W-1:0] data_out,
	output logic              line_valid,
	output logic              tx_irq_enable,
	output logic              rx_irq_enable,
	output logic [LEVEL_W-1:0] tx_level,
	output logic [LEVEL_W-1:0] rx_level
);

	logic [DATA_W-1:0] tx_mem [QUEUE_DEPTH];
	logic [DATA_W-1:0] rx_mem [QUEUE_DEPTH];

	cmd_t cmd_q;
	logic [DATA_W-1:0] din_q;
	logic [PTR_W-1:0] tx_head_q, tx_tail_q, rx_head_q, rx_tail_q;
	logic [FILL_W-1:0] tx_fill_q, rx_fill_q;
	logic tx_int_q, rx_int_q;
	logic status_q, line_valid_q, pop_q, pop_tx_q;
	logic [DATA_W-1:0] tx_rd_q, rx_rd_q;

	logic tx_full, tx_empty, rx_full, rx_empty;
	logic tx_we, tx_re, rx_we, rx_re;

	assign tx_full = (tx_fill_q == FILL_FULL);
	assign tx_empty = (tx_fill_q == '0);
	assign rx_full = (rx_fill_q == FILL_FULL);
	assign rx_empty = (rx_fill_q == '0);

	assign tx_we = ctrl.exec && (cmd_q == CMD_PUT) && !tx_full;
	assign tx_re = ctrl.exec && (cmd_q == CMD_TXRDY) && !tx_empty;
	assign rx_we = ctrl.exec && (cmd_q == CMD_RXBYTE) && !rx_full;
	assign rx_re = ctrl.exec && (cmd_q == CMD_GET) && !rx_empty;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd_t'(cmd);
			din_q <= data_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tx_we) begin
			tx_mem[tx_tail_q] <= din_q;
		end
		if (tx_re) begin
			tx_rd_q <= tx_mem[tx_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_mem[rx_tail_q] <= din_q;
		end
		if (rx_re) begin
			rx_rd_q <= rx_mem[rx_head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_fill_q <= '0;
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_fill_q <= '0;
			tx_int_q <= 1'b0;
			rx_int_q <= 1'b0;
			status_q <= 1'b0;
			line_valid_q <= 1'b0;
			pop_q <= 1'b0;
			pop_tx_q <= 1'b0;
		end else if (ctrl.exec) begin
			status_q <= 1'b0;
			line_valid_q <= 1'b0;
			pop_q <= 1'b0;
			pop_tx_q <= 1'b0;
			unique case (cmd_q)
				CMD_PUT: begin
					if (tx_full) begin
						status_q <= 1'b1;
					end else begin
						tx_tail_q <= ptr_next(tx_tail_q);
						tx_fill_q <= tx_fill_q + FILL_ONE;
					end
					tx_int_q <= 1'b1;
				end
				CMD_GET: begin
					if (rx_empty) begin
						status_q <= 1'b1;
					end else begin
						rx_head_q <= ptr_next(rx_head_q);
						rx_fill_q <= rx_fill_q - FILL_ONE;
						pop_q <= 1'b1;
					end
					rx_int_q <= 1'b1;
				end
				CMD_TXRDY: begin
					if (!tx_empty) begin
						tx_head_q <= ptr_next(tx_head_q);
						tx_fill_q <= tx_fill_q - FILL_ONE;
						pop_q <= 1'b1;
						pop_tx_q <= 1'b1;
						line_valid_q <= 1'b1;
					end
					if (tx_fill_q <= FILL_ONE) begin
						tx_int_q <= 1'b0;
					end
				end
				CMD_RXBYTE: begin
					if (!rx_full) begin
						rx_tail_q <= ptr_next(rx_tail_q);
						rx_fill_q <= rx_fill_q + FILL_ONE;
					end
					if (rx_fill_q >= FILL_ALMOST_FULL) begin
						rx_int_q <= 1'b0;
					end
				end
				default: begin
					status_q <= 1'b0;
				end
			endcase
		end
	end

	assign status = status_q;
	assign line_valid = line_valid_q;
	assign data_out = pop_q ? (pop_tx_q ? tx_rd_q : rx_rd_q) : '0;
	assign tx_irq_enable = tx_int_q;
	assign rx_irq_enable = rx_int_q;
	assign tx_level = LEVEL_W'(tx_fill_q);
	assign rx_level = LEVEL_W'(rx_fill_q);

endmodule

FILE: src/uart_tx_rx_ring_buffers.sv
// Top level of the UART transmit and receive ring buffers.
//
// Channel   Direction  Transfer when        Signals
// command   in         start && !busy       cmd, data_in
// result    out        done (one cycle)     status, data_out, line_valid, tx_irq_enable,
//                                           rx_irq_enable, tx_level, rx_level
//
// S_EXEC updates the queues and reads the memory port; S_DONE presents the result with
// done. A new command may be accepted in the result cycle. Reset clears the pointers,
// fill counts and interrupt enables; the byte stores are not cleared. The result
// receiver cannot stall, so a result is shown for exactly one cycle.
module uart_tx_rx_ring_buffers
	import utrb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [DATA_W-1:0]  data_in,
	output logic               done,
	output logic               status,
	output logic [DATA_W-1:0]  data_out,
	output logic               line_valid,
	output logic               tx_irq_enable,
	output logic               rx_irq_enable,
	output logic [LEVEL_W-1:0] tx_level,
	output logic [LEVEL_W-1:0] rx_level
);

	ctrl_cmd_t ctrl;

	utrb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	utrb_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cmd           (cmd),
		.data_in       (data_in),
		.status        (status),
		.data_out      (data_out),
		.line_valid    (line_valid),
		.tx_irq_enable (tx_irq_enable),
		.rx_irq_enable (rx_irq_enable),
		.tx_level      (tx_level),
		.rx_level      (rx_level)
	);

endmodule
